### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Types and codes shared by the matrix multiply sequencer and its units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_COLS_B     = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_POST  = 4'b1000
    } t_state;

    // Tag that travels with each multiply-accumulate step.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctrl;

endpackage

### rtl/mm_store.sv
// ----------------------------------------------------------------------------
// mm_store
// Single-port-write, single-port-read element memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mm_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/mm_mac.sv
// ----------------------------------------------------------------------------
// mm_mac
// Shared multiply-accumulate unit with truncation toward zero and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mm_mac #(
    parameter int ACC_W     = 68,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mm_pkg::t_mac_ctrl   i_ctrl,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output logic                o_res_valid,
    output logic [31:0]         o_res_data,
    output logic                o_res_sat
);

    import mm_pkg::*;

    localparam logic [ACC_W-1:0] BIAS = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);

    t_mac_ctrl                 r_s1;
    t_mac_ctrl                 r_s2;
    t_mac_ctrl                 r_s3;
    logic signed [63:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   adj;
    logic signed [ACC_W-1:0]   quot;
    logic                      over_pos;
    logic                      over_neg;
    logic                      r_res_valid;
    logic [31:0]               r_res_data;
    logic                      r_res_sat;

    // Tag pipeline: s1 lines up with the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= i_ctrl;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Accumulate stage; the first step of an element restarts the sum.
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_s2.valid) begin
            r_acc <= r_s2.first ? prod_ext : r_acc + prod_ext;
        end
    end

    // Truncate toward zero: bias negative sums before the arithmetic shift.
    always_comb begin
        adj      = r_acc + (r_acc[ACC_W-1] ? BIAS : '0);
        quot     = adj >>> FRAC_BITS;
        over_pos = !quot[ACC_W-1] && (|quot[ACC_W-2:31]);
        over_neg = quot[ACC_W-1] && !(&quot[ACC_W-2:31]);
    end

    // Result stage, held until the next element finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_s3.valid && r_s3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3.valid && r_s3.last) begin
            r_res_sat <= over_pos || over_neg;
            if (over_pos) begin
                r_res_data <= 32'h7FFF_FFFF;
            end else if (over_neg) begin
                r_res_data <= 32'h8000_0000;
            end else begin
                r_res_data <= quot[31:0];
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;
    assign o_res_sat   = r_res_sat;

endmodule

### rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// Loads two fixed-point matrices element by element and streams their product.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       sink       i_valid / o_ready         operand_sel, row, col, element, start
// out      source     o_valid / i_ready         out_row, out_col, product, saturated, last
// cfg      sink       i_cfg_valid / o_cfg_ready  index, data
//
// An item with start set occupies the block until its last product is handed off:
// one shared multiply-accumulate unit takes one step per cycle and each product
// element passes through the read, product, accumulate and result registers and a
// hand-off state. Reset is synchronous and needs no clearing pass.
// A stalled output holds the sequencer before it hands off the next element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input items.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operand_sel,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_col_index,
    input  logic signed [31:0] i_element,
    input  logic               i_start_req,
    // Result items.
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_out_row,
    output logic [2:0]         o_out_col,
    output logic signed [31:0] o_product,
    output logic               o_saturated,
    output logic               o_last,
    // Configuration writes.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    import mm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ACC_W  = 64 + IDX_W + 1;

    t_state             r_state, n_state;
    logic [3:0]         r_rows_a, r_inner_size, r_cols_b;
    logic [IDX_W-1:0]   r_last_i, r_last_t, r_last_j;
    logic [IDX_W-1:0]   r_i, n_i, r_j, n_j, r_t, n_t;
    logic               r_o_valid;
    logic [2:0]         r_o_row, r_o_col;
    logic [31:0]        r_o_product;
    logic               r_o_sat, r_o_last;

    logic               in_acc;
    logic               in_range;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
    logic [31:0]        rd_a, rd_b;
    t_mac_ctrl          issue_ctrl;
    logic               res_valid;
    logic [31:0]        res_data;
    logic               res_sat;
    logic               out_free;
    logic               run_end;

    // Effective dimension minus one: zero acts as one, large values clamp.
    function automatic logic [IDX_W-1:0] dim_last(input logic [3:0] v);
        logic [IDX_W-1:0] d;
        if (v == 4'd0) begin
            d = '0;
        end else if ({1'b0, v} > 5'(MAX_DIM)) begin
            d = IDX_W'(MAX_DIM - 1);
        end else begin
            d = IDX_W'(v - 4'd1);
        end
        return d;
    endfunction

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= 4'd3;
            r_inner_size <= 4'd3;
            r_cols_b     <= 4'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:     r_rows_a     <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_B:     r_cols_b     <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Element stores; indexes outside the store are dropped.
    assign in_range  = (5'(i_row_index) < 5'(MAX_DIM)) && (5'(i_col_index) < 5'(MAX_DIM));
    assign wr_addr   = ADDR_W'(32'(i_row_index) * MAX_DIM + 32'(i_col_index));
    assign rd_addr_a = ADDR_W'(32'(r_i) * MAX_DIM + 32'(r_t));
    assign rd_addr_b = ADDR_W'(32'(r_t) * MAX_DIM + 32'(r_j));

    mm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (32)
    ) u_left (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && !i_operand_sel && in_range),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_element),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (rd_a)
    );

    mm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (32)
    ) u_right (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && i_operand_sel && in_range),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_element),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (rd_b)
    );

    // Shared multiply-accumulate unit.
    always_comb begin
        issue_ctrl.valid = (r_state == ST_ISSUE);
        issue_ctrl.first = (r_t == '0);
        issue_ctrl.last  = (r_t == r_last_t);
    end

    mm_mac #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (issue_ctrl),
        .i_a         (rd_a),
        .i_b         (rd_b),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .o_res_sat   (res_sat)
    );

    assign out_free = !r_o_valid || i_ready;
    assign run_end  = (r_i == r_last_i) && (r_j == r_last_j);

    // Sequencer: walk the inner index per element, then rows and columns.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_start_req) begin
                    n_state = ST_ISSUE;
                    n_i     = '0;
                    n_j     = '0;
                    n_t     = '0;
                end
            end
            ST_ISSUE: begin
                if (r_t == r_last_t) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_t = r_t + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (res_valid) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (out_free) begin
                    n_t = '0;
                    if (run_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_ISSUE;
                        if (r_j == r_last_j) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_t     <= n_t;
        end
    end

    // Run dimensions are latched when the start item arrives.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_start_req) begin
            r_last_i <= dim_last(r_rows_a);
            r_last_t <= dim_last(r_inner_size);
            r_last_j <= dim_last(r_cols_b);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_POST && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_POST && out_free) begin
            r_o_row     <= 3'(r_i);
            r_o_col     <= 3'(r_j);
            r_o_product <= res_data;
            r_o_sat     <= res_sat;
            r_o_last    <= run_end;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_product   = r_o_product;
    assign o_saturated = r_o_sat;
    assign o_last      = r_o_last;

endmodule

### rtl/mm_checker.sv
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks on the matrix multiply block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_start_req,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_product,
    input logic               o_saturated,
    input logic               o_last
);

    logic at_rail;

    // The product sits on the positive or the negative limit.
    assign at_rail = (o_product == 32'sh7FFF_FFFF) || (o_product == 32'sh8000_0000);

    // A stalled result item holds its value.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_product))

    // A start item makes the block busy on the next cycle.
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_valid && o_ready && i_start_req, !o_ready)

    // A clamped result is one of the two rails.
    `ASSERT_IMPLIES(a_sat_rail, i_clk, i_rst_n, o_valid && o_saturated, at_rail)

    // While a run is still being delivered, no new item is taken.
    `ASSERT_IMPLIES(a_run_busy, i_clk, i_rst_n, o_valid && !o_last, !o_ready)

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_start_req (i_start_req),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_product   (o_product),
    .o_saturated (o_saturated),
    .o_last      (o_last)
);
